[rtl/ilstk_pkg.sv]
// Shared constants, command and status codes, and types for the indexed LIFO stack.
`timescale 1ns / 1ps
package ilstk_pkg;

	localparam int DEPTH_DEF     = 8;
	localparam int WORD_BITS_DEF = 32;

	localparam int CMD_BITS    = 3;
	localparam int STATUS_BITS = 2;

	localparam logic [CMD_BITS-1:0] CMD_PUSH  = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_POP   = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_PEEK  = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_WRITE = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR = 3'd4;

	localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd3;

	// Result-stage control handed from the command controller to the output stage
	typedef struct packed {
		logic                   valid;
		logic [STATUS_BITS-1:0] status;
		logic                   rd_ok;
	} ilstk_res_t;

endpackage

[rtl/ilstk_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module ilstk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write the addressed word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register the read word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/ilstk_ctrl.sv]
// Command controller: decodes commands, keeps the fill count and drives the entry RAM.
`timescale 1ns / 1ps
module ilstk_ctrl #(
	parameter int DEPTH     = 8,
	parameter int WORD_BITS = 32
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       accept,
	input  logic [ilstk_pkg::CMD_BITS-1:0]             cmd,
	input  logic [WORD_BITS-1:0]                       value_in,
	input  logic [$clog2(DEPTH+1)-1:0]                 position,
	output logic                                       mem_we,
	output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_waddr,
	output logic [WORD_BITS-1:0]                       mem_wdata,
	output logic                                       mem_re,
	output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_raddr,
	output logic [$clog2(DEPTH+1)-1:0]                 count,
	output ilstk_pkg::ilstk_res_t                      res
);

	import ilstk_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [CW-1:0]          count_q;
	logic [CW-1:0]          count_d;
	logic [CW-1:0]          slot_full;
	logic [AW-1:0]          slot;
	logic                   pos_bad;
	logic                   is_empty_now;
	logic                   is_full_now;
	logic [STATUS_BITS-1:0] status_d;
	logic                   rd_ok_d;
	ilstk_res_t             res_s1;

	// Map a depth from the top to a slot index
	assign slot_full    = count_q - position;
	assign slot         = slot_full[AW-1:0];
	assign pos_bad      = (position == '0) || (position > count_q);
	assign is_empty_now = (count_q == '0);
	assign is_full_now  = (count_q == FULL_COUNT);

	// Decode the command into status, count update and RAM access.
	// Slots at or above the count are never read before a push writes them,
	// so pop and clear need no zeroing sweep; pop still zeroes its slot.
	always_comb begin
		status_d  = ST_OK;
		rd_ok_d   = 1'b0;
		count_d   = count_q;
		mem_we    = 1'b0;
		mem_waddr = slot;
		mem_wdata = value_in;
		mem_re    = 1'b0;
		mem_raddr = slot;
		unique case (cmd)
			CMD_PUSH: begin
				if (is_full_now) begin
					status_d = ST_FULL;
				end else begin
					mem_we    = accept;
					mem_waddr = count_q[AW-1:0];
					count_d   = count_q + CW'(1);
				end
			end
			CMD_POP: begin
				if (is_empty_now) begin
					status_d = ST_EMPTY;
				end else begin
					count_d   = count_q - CW'(1);
					mem_we    = accept;
					mem_waddr = count_d[AW-1:0];
					mem_wdata = '0;
				end
			end
			CMD_PEEK: begin
				if (is_empty_now) begin
					status_d = ST_EMPTY;
				end else if (pos_bad) begin
					status_d = ST_RANGE;
				end else begin
					rd_ok_d = 1'b1;
					mem_re  = accept;
				end
			end
			CMD_WRITE: begin
				if (pos_bad) begin
					status_d = ST_RANGE;
				end else begin
					mem_we = accept;
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// Advance the fill count and the result stage on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			res_s1  <= '0;
		end else begin
			res_s1.valid <= accept;
			if (accept) begin
				count_q       <= count_d;
				res_s1.status <= status_d;
				res_s1.rd_ok  <= rd_ok_d;
			end
		end
	end

	assign count = count_q;
	assign res   = res_s1;

endmodule

[rtl/indexed_lifo_stack.sv]
// Indexed LIFO stack: accepts one command per cycle and returns one result per command.
// Each result appears on the result ports, marked by done, in the cycle after its accepted start.
// Throughput: one command per cycle; busy is tied low, so the block never stalls.
// A peek reads the entry RAM at acceptance and its word leaves the registered read port.
// Reset clears the fill count and the result strobe; RAM contents stay as they are.
// The receiver cannot stall: each result is held for exactly one cycle.
`timescale 1ns / 1ps
module indexed_lifo_stack #(
	parameter int DEPTH     = ilstk_pkg::DEPTH_DEF,
	parameter int WORD_BITS = ilstk_pkg::WORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [ilstk_pkg::CMD_BITS-1:0]      cmd,
	input  logic [WORD_BITS-1:0]                value_in,
	input  logic [$clog2(DEPTH+1)-1:0]          position,
	output logic                                done,
	output logic [ilstk_pkg::STATUS_BITS-1:0]   status,
	output logic [WORD_BITS-1:0]                value_out,
	output logic [$clog2(DEPTH+1)-1:0]          fill_count,
	output logic                                is_full,
	output logic                                is_empty
);

	import ilstk_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic                 accept;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;
	logic [CW-1:0]        count;
	ilstk_res_t           res;

	// Take a command every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	ilstk_ctrl #(
		.DEPTH    (DEPTH),
		.WORD_BITS(WORD_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.value_in (value_in),
		.position (position),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.count    (count),
		.res      (res)
	);

	ilstk_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Drive the result transaction; drop the read word unless a peek succeeded
	assign done       = res.valid;
	assign status     = res.status;
	assign value_out  = res.rd_ok ? mem_rdata : '0;
	assign fill_count = count;
	assign is_full    = (count == FULL_COUNT);
	assign is_empty   = (count == '0);

`ifndef SYNTHESIS
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result strobe without an accepted transaction");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count <= FULL_COUNT)
		else $error("fill count beyond capacity");

	a_word_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && value_out != '0) |-> (status == ST_OK && $past(cmd) == CMD_PEEK))
		else $error("nonzero word on a result that is not a successful peek");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd != CMD_CLEAR) |=>
		(fill_count == $past(fill_count) || fill_count == $past(fill_count) + CW'(1)
		|| fill_count == $past(fill_count) - CW'(1)))
		else $error("fill count moved by more than one");
`endif

endmodule

[sim/indexed_lifo_stack_tb.sv]
// Self-checking testbench for the indexed LIFO stack: directed table, then random commands.
`timescale 1ns / 1ps
module indexed_lifo_stack_tb;
	import ilstk_pkg::*;

	localparam int STK_DEPTH = DEPTH_DEF;
	localparam int STK_WORD  = WORD_BITS_DEF;
	localparam int POS_BITS  = $clog2(STK_DEPTH + 1);

	// Command codes the block treats as no operation
	localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS = 550;
	localparam int CYCLE_LIMIT  = 60000;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_PRINTED  = 64;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [STK_WORD-1:0]    word;
		logic [POS_BITS-1:0]    count;
		logic                   full;
		logic                   empty;
	} stack_reply_t;

	typedef struct packed {
		logic [CMD_BITS-1:0] op;
		logic [STK_WORD-1:0] word;
		logic [POS_BITS-1:0] pos;
		logic                typed;
		stack_reply_t        reply;
	} stack_row_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [CMD_BITS-1:0]    cmd = CMD_PUSH;
	logic [STK_WORD-1:0]    value_in = '0;
	logic [POS_BITS-1:0]    position = '0;
	logic                   done;
	logic [STATUS_BITS-1:0] status;
	logic [STK_WORD-1:0]    value_out;
	logic [POS_BITS-1:0]    fill_count;
	logic                   is_full;
	logic                   is_empty;

	// Typed-in expectation that rides along with a directed transaction
	logic         row_typed = 1'b0;
	stack_reply_t row_reply = '0;

	// Predictor state
	logic [STK_WORD-1:0] shadow_mem [STK_DEPTH];
	logic [POS_BITS-1:0] shadow_count;

	stack_reply_t pending_replies [$];
	stack_reply_t got_reply;
	stack_reply_t want_reply;
	int           mismatch_count = 0;
	int           cycle_count = 0;
	int           gen_count = 0;

	// Directed table: typed expectations only where obvious, the rest goes to the predictor
	stack_row_t directed_rows [26] = '{
		'{CMD_POP,   32'h0000_0000, 4'd0,  1'b1, '{ST_EMPTY, 32'h0,          4'd0, 1'b0, 1'b1}},
		'{CMD_PEEK,  32'h0000_0000, 4'd1,  1'b1, '{ST_EMPTY, 32'h0,          4'd0, 1'b0, 1'b1}},
		'{CMD_WRITE, 32'h0000_1234, 4'd1,  1'b1, '{ST_RANGE, 32'h0,          4'd0, 1'b0, 1'b1}},
		'{CMD_PUSH,  32'hFFFF_FFFF, 4'd0,  1'b1, '{ST_OK,    32'h0,          4'd1, 1'b0, 1'b0}},
		'{CMD_PEEK,  32'h0000_0000, 4'd0,  1'b1, '{ST_RANGE, 32'h0,          4'd1, 1'b0, 1'b0}},
		'{CMD_PEEK,  32'h0000_0000, 4'd1,  1'b1, '{ST_OK,    32'hFFFF_FFFF,  4'd1, 1'b0, 1'b0}},
		'{CMD_PEEK,  32'h0000_0000, 4'd2,  1'b1, '{ST_RANGE, 32'h0,          4'd1, 1'b0, 1'b0}},
		'{CMD_PUSH,  32'h0000_0000, 4'd0,  1'b0, '0},
		'{CMD_PUSH,  32'h0000_0001, 4'd0,  1'b0, '0},
		'{CMD_PUSH,  32'h8000_0000, 4'd0,  1'b0, '0},
		'{CMD_PUSH,  32'hA5A5_A5A5, 4'd0,  1'b0, '0},
		'{CMD_PUSH,  32'h5A5A_5A5A, 4'd0,  1'b0, '0},
		'{CMD_PUSH,  32'h7FFF_FFFF, 4'd0,  1'b0, '0},
		'{CMD_PUSH,  32'hFFFF_0000, 4'd0,  1'b0, '0},
		'{CMD_PUSH,  32'hDEAD_BEEF, 4'd0,  1'b1, '{ST_FULL,  32'h0,          4'd8, 1'b1, 1'b0}},
		'{CMD_PEEK,  32'h0000_0000, 4'd8,  1'b1, '{ST_OK,    32'hFFFF_FFFF,  4'd8, 1'b1, 1'b0}},
		'{CMD_PEEK,  32'h0000_0000, 4'd9,  1'b1, '{ST_RANGE, 32'h0,          4'd8, 1'b1, 1'b0}},
		'{CMD_WRITE, 32'h1234_5678, 4'd8,  1'b0, '0},
		'{CMD_PEEK,  32'h0000_0000, 4'd8,  1'b0, '0},
		'{CMD_WRITE, 32'hCAFE_F00D, 4'd15, 1'b1, '{ST_RANGE, 32'h0,          4'd8, 1'b1, 1'b0}},
		'{CMD_SPARE_HI, 32'hFFFF_FFFF, 4'd15, 1'b1, '{ST_OK, 32'h0,          4'd8, 1'b1, 1'b0}},
		'{CMD_POP,   32'h0000_0000, 4'd0,  1'b0, '0},
		'{CMD_CLEAR, 32'h0000_0000, 4'd0,  1'b1, '{ST_OK,    32'h0,          4'd0, 1'b0, 1'b1}},
		'{CMD_POP,   32'h0000_0000, 4'd0,  1'b1, '{ST_EMPTY, 32'h0,          4'd0, 1'b0, 1'b1}},
		'{CMD_PUSH,  32'h0F0F_0F0F, 4'd0,  1'b0, '0},
		'{CMD_PEEK,  32'h0000_0000, 4'd1,  1'b0, '0}
	};

	indexed_lifo_stack uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.value_in   (value_in),
		.position   (position),
		.done       (done),
		.status     (status),
		.value_out  (value_out),
		.fill_count (fill_count),
		.is_full    (is_full),
		.is_empty   (is_empty)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Apply one command to the shadow stack and return the reply it should produce
	function automatic stack_reply_t stack_apply(input logic [CMD_BITS-1:0] op,
			input logic [STK_WORD-1:0] word, input logic [POS_BITS-1:0] pos);
		stack_reply_t r;
		int           slot;
		r = '0;
		r.status = ST_OK;
		slot = (pos == 0 || pos > shadow_count) ? -1 : int'(shadow_count) - int'(pos);
		case (op)
			CMD_PUSH: begin
				if (shadow_count >= STK_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_mem[shadow_count] = word;
					shadow_count = shadow_count + 1'b1;
				end
			end
			CMD_POP: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					shadow_count = shadow_count - 1'b1;
					shadow_mem[shadow_count] = '0;
				end
			end
			CMD_PEEK: begin
				if (shadow_count == 0)
					r.status = ST_EMPTY;
				else if (slot < 0)
					r.status = ST_RANGE;
				else
					r.word = shadow_mem[slot];
			end
			CMD_WRITE: begin
				if (slot < 0)
					r.status = ST_RANGE;
				else
					shadow_mem[slot] = word;
			end
			CMD_CLEAR: begin
				for (int i = 0; i < STK_DEPTH; i++)
					shadow_mem[i] = '0;
				shadow_count = '0;
			end
			default: begin
			end
		endcase
		r.count = shadow_count;
		r.full  = (shadow_count == STK_DEPTH);
		r.empty = (shadow_count == 0);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [STK_WORD-1:0] got,
			input logic [STK_WORD-1:0] want);
		if (mismatch_count < MAX_PRINTED)
			$display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Check each result against the oldest expectation, then log the new transaction
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			got_reply = '{status, value_out, fill_count, is_full, is_empty};
			if (pending_replies.size() == 0) begin
				report_mismatch("result with nothing pending", got_reply.word, '0);
			end else begin
				want_reply = pending_replies.pop_front();
				if (got_reply.status !== want_reply.status)
					report_mismatch("status", got_reply.status, want_reply.status);
				if (got_reply.word !== want_reply.word)
					report_mismatch("value_out", got_reply.word, want_reply.word);
				if (got_reply.count !== want_reply.count)
					report_mismatch("fill_count", got_reply.count, want_reply.count);
				if (got_reply.full !== want_reply.full)
					report_mismatch("is_full", got_reply.full, want_reply.full);
				if (got_reply.empty !== want_reply.empty)
					report_mismatch("is_empty", got_reply.empty, want_reply.empty);
			end
		end
		if (arst_n && start && busy === 1'b0) begin
			want_reply = stack_apply(cmd, value_in, position);
			pending_replies.push_back(row_typed ? row_reply : want_reply);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Drive one transaction and hold it until the block takes it
	task automatic send_command(input logic [CMD_BITS-1:0] op, input logic [STK_WORD-1:0] word,
			input logic [POS_BITS-1:0] pos, input logic typed, input stack_reply_t reply);
		start     <= 1'b1;
		cmd       <= op;
		value_in  <= word;
		position  <= pos;
		row_typed <= typed;
		row_reply <= reply;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		// Track the fill level to steer positions toward valid depths
		case (op)
			CMD_PUSH:  if (gen_count < STK_DEPTH) gen_count++;
			CMD_POP:   if (gen_count > 0) gen_count--;
			CMD_CLEAR: gen_count = 0;
			default: begin
			end
		endcase
	endtask

	// Idle the sender for a random gap with the given percent odds
	task automatic sender_gap(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Hold off until every pending result has come back
	task automatic drain_replies();
		start <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random();
		int                  roll;
		logic [CMD_BITS-1:0] op;
		logic [POS_BITS-1:0] pos;
		logic [STK_WORD-1:0] word;
		roll = $urandom_range(0, 99);
		word = $urandom;
		if (roll < 32)
			op = CMD_PUSH;
		else if (roll < 54)
			op = CMD_POP;
		else if (roll < 78)
			op = CMD_PEEK;
		else if (roll < 96)
			op = CMD_WRITE;
		else if (roll < 98)
			op = CMD_CLEAR;
		else
			op = CMD_BITS'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		// Mostly valid depths, some zero or past the fill level
		if (gen_count > 0 && $urandom_range(0, 99) < 85)
			pos = POS_BITS'($urandom_range(1, gen_count));
		else
			pos = POS_BITS'($urandom_range(0, 15));
		send_command(op, word, pos, 1'b0, '0);
	endtask

	initial begin
		for (int i = 0; i < STK_DEPTH; i++)
			shadow_mem[i] = '0;
		shadow_count = '0;

		// Hold reset, release on a rising edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (directed_rows[i])
			send_command(directed_rows[i].op, directed_rows[i].word, directed_rows[i].pos,
				directed_rows[i].typed, directed_rows[i].reply);
		drain_replies();

		// Random part in three phases with different idle odds, draining after each
		for (int phase = 0; phase < 3; phase++) begin
			for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
				sender_gap(phase == 0 ? 15 : (phase == 1 ? 46 : 0));
				send_random();
			end
			drain_replies();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
